/* src/mfh_pkg.sv */
// Shared constants for the magnetometer field and heading block:
// divisor and reciprocal tables, the CORDIC angle table and pipeline depths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfh_pkg;

    localparam int RAW_W    = 16;
    localparam int GAUSS_W  = 25;
    localparam int HEAD_W   = 17;
    localparam int GAIN_W   = 3;
    localparam int N_GAIN   = 8;

    localparam int DIV_W    = 11;
    localparam int RECIP_W  = 25;

    // counts per gauss for each gain setting
    localparam logic [DIV_W-1:0] DIVISOR [N_GAIN] = '{
        11'd1370, 11'd1090, 11'd820, 11'd660, 11'd440, 11'd390, 11'd330, 11'd230
    };

    // floor(2^32 / divisor)
    localparam logic [RECIP_W-1:0] RECIP [N_GAIN] = '{
        25'((64'd1 << 32) / 64'd1370), 25'((64'd1 << 32) / 64'd1090),
        25'((64'd1 << 32) / 64'd820),  25'((64'd1 << 32) / 64'd660),
        25'((64'd1 << 32) / 64'd440),  25'((64'd1 << 32) / 64'd390),
        25'((64'd1 << 32) / 64'd330),  25'((64'd1 << 32) / 64'd230)
    };

    localparam int CORDIC_ITERS = 20;
    localparam int CX_W         = 32;
    localparam int Z_W          = 25;

    // atan(2^-i) in units of 2^-16 degree
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
        25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
        25'sd115,     25'sd57,      25'sd29,     25'sd14,     25'sd7
    };

    localparam logic signed [Z_W-1:0] ANG_90    = 25'sd5898240;
    localparam logic [HEAD_W:0]       DEG90_Q8  = 18'd23040;
    localparam logic [HEAD_W:0]       DEG180_Q8 = 18'd46080;
    localparam logic [HEAD_W:0]       DEG360_Q8 = 18'd92160;

    // pipeline depths in enabled cycles
    localparam int DIV_LAT    = 4;
    localparam int CORDIC_LAT = CORDIC_ITERS + 2;
    localparam int ALIGN_LAT  = CORDIC_LAT - DIV_LAT;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
    } quad_t;

endpackage
`default_nettype wire

/* src/mfh_div_lane.sv */
// One gauss conversion lane: |raw| * 2^16 / divisor by reciprocal multiply
// with one correction step, sign restored at the end. Uses mfh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfh_div_lane
    import mfh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [RAW_W-1:0]  raw,
    input  wire logic [GAIN_W-1:0]        gain,
    output logic signed [GAUSS_W-1:0]     gauss
);

    logic                 neg_a_reg, neg_b_reg, neg_c_reg;
    logic [RAW_W-1:0]     mag_a_reg, mag_b_reg;
    logic [GAIN_W-1:0]    idx_a_reg, idx_b_reg, idx_c_reg;
    logic [RECIP_W-1:0]   qe_b_reg, qe_c_reg;
    logic [31:0]          qd_c_reg, num_c_reg;
    logic signed [GAUSS_W-1:0] gauss_reg;

    logic [RAW_W:0]       raw_abs;
    logic [RAW_W+RECIP_W-1:0] prod;
    logic [RECIP_W+DIV_W-1:0] qd;
    logic [31:0]          rem;
    logic [RECIP_W-1:0]   q_fix;

    always_comb
    begin
        raw_abs = raw[RAW_W-1] ? (17'd0 - 17'(raw)) : 17'(raw);
        prod    = (RAW_W+RECIP_W)'(mag_a_reg) * (RAW_W+RECIP_W)'(RECIP[idx_a_reg]);
        qd      = (RECIP_W+DIV_W)'(qe_b_reg) * (RECIP_W+DIV_W)'(DIVISOR[idx_b_reg]);
        rem     = num_c_reg - qd_c_reg;
        // estimate is at most one short
        q_fix   = qe_c_reg + ((rem >= 32'(DIVISOR[idx_c_reg])) ? 25'd1 : 25'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= raw[RAW_W-1];
            mag_a_reg <= raw_abs[RAW_W-1:0];
            idx_a_reg <= gain;

            neg_b_reg <= neg_a_reg;
            mag_b_reg <= mag_a_reg;
            idx_b_reg <= idx_a_reg;
            qe_b_reg  <= prod[RAW_W+RECIP_W-1:16];

            neg_c_reg <= neg_b_reg;
            idx_c_reg <= idx_b_reg;
            qe_c_reg  <= qe_b_reg;
            qd_c_reg  <= qd[31:0];
            num_c_reg <= {mag_b_reg, 16'd0};

            gauss_reg <= neg_c_reg ? (25'sd0 - $signed(q_fix)) : $signed(q_fix);
        end
    end

    assign gauss = gauss_reg;

endmodule
`default_nettype wire

/* src/mfh_cordic.sv */
// Heading pipeline: vectoring CORDIC, one iteration per stage, then clamp,
// rounding and quadrant mapping into [0, 360) degrees. Uses mfh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfh_cordic
    import mfh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [RAW_W-1:0]  fx,
    input  wire logic signed [RAW_W-1:0]  fy,
    output logic [HEAD_W-1:0]             heading
);

    logic signed [CX_W-1:0] x_reg [CORDIC_ITERS+1];
    logic signed [CX_W-1:0] y_reg [CORDIC_ITERS+1];
    logic signed [Z_W-1:0]  z_reg [CORDIC_ITERS+1];
    quad_t                  q_reg [CORDIC_ITERS+1];
    logic [HEAD_W-1:0]      heading_reg;

    logic [RAW_W:0] ax, ay;

    always_comb
    begin
        ax = fx[RAW_W-1] ? (17'd0 - 17'(fx)) : 17'(fx);
        ay = fy[RAW_W-1] ? (17'd0 - 17'(fy)) : 17'(fy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]        <= $signed({1'b0, ax, 14'd0});
            y_reg[0]        <= $signed({1'b0, ay, 14'd0});
            z_reg[0]        <= '0;
            q_reg[0].neg_x  <= fx[RAW_W-1];
            q_reg[0].neg_y  <= fy[RAW_W-1];
            q_reg[0].zero_x <= (fx == '0);
            q_reg[0].zero_y <= (fy == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        logic signed [CX_W-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    logic signed [Z_W-1:0] z_end, z_clamp;
    logic [22:0]           z_rnd;
    logic [HEAD_W:0]       a, h;
    quad_t                 q_end;

    always_comb
    begin
        z_end = z_reg[CORDIC_ITERS];
        q_end = q_reg[CORDIC_ITERS];
        if (z_end < 0)
            z_clamp = '0;
        else if (z_end > ANG_90)
            z_clamp = ANG_90;
        else
            z_clamp = z_end;
        z_rnd = z_clamp[22:0] + 23'd128;

        if (q_end.zero_y)
            a = '0;
        else if (q_end.zero_x)
            a = DEG90_Q8;
        else
            a = 18'(z_rnd[22:8]);

        if (!q_end.neg_x && !q_end.neg_y)
            h = a;
        else if (q_end.neg_x && !q_end.neg_y)
            h = DEG180_Q8 - a;
        else if (q_end.neg_x)
            h = DEG180_Q8 + a;
        else
            h = DEG360_Q8 - a;
        // exactly 360 wraps to 0
        if (h >= DEG360_Q8)
            h = h - DEG360_Q8;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            heading_reg <= h[HEAD_W-1:0];
    end

    assign heading = heading_reg;

endmodule
`default_nettype wire

/* src/magnetometer_field_and_heading.sv */
// Path: CORDIC input register, iteration stages, heading register, output register.
// Throughput: one word per cycle; the 20-stage CORDIC and the 4-stage divider lanes
// advance together, and the whole pipeline holds while a result waits under out_stall.
// Reset: rst_n clears the valid pipeline and output valid; gain_reg returns to 1.
// Uses mfh_pkg, mfh_div_lane, mfh_cordic.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_field_and_heading
    import mfh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [GAIN_W-1:0]        cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [RAW_W-1:0]  field_x,
    input  wire logic signed [RAW_W-1:0]  field_y,
    input  wire logic signed [RAW_W-1:0]  field_z,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [GAUSS_W-1:0]     gauss_x_out,
    output logic signed [GAUSS_W-1:0]     gauss_y_out,
    output logic signed [GAUSS_W-1:0]     gauss_z_out,
    output logic [HEAD_W-1:0]             heading_deg
);

    logic [GAIN_W-1:0]     gain_reg;
    logic [CORDIC_LAT-1:0] vld_reg;
    logic                  out_valid_reg;
    logic                  adv;

    logic signed [GAUSS_W-1:0] gx, gy, gz;
    logic [HEAD_W-1:0]         hd;

    logic signed [GAUSS_W-1:0] dx_reg [ALIGN_LAT];
    logic signed [GAUSS_W-1:0] dy_reg [ALIGN_LAT];
    logic signed [GAUSS_W-1:0] dz_reg [ALIGN_LAT];

    logic signed [GAUSS_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [HEAD_W-1:0]         hd_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign adv      = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_W'(1);
        else if (cfg_we)
            gain_reg <= cfg_wdata;
    end

    mfh_div_lane u_lane_x (.clk(clk), .en(adv), .raw(field_x), .gain(gain_reg), .gauss(gx));
    mfh_div_lane u_lane_y (.clk(clk), .en(adv), .raw(field_y), .gain(gain_reg), .gauss(gy));
    mfh_div_lane u_lane_z (.clk(clk), .en(adv), .raw(field_z), .gain(gain_reg), .gauss(gz));

    mfh_cordic u_cordic (.clk(clk), .en(adv), .fx(field_x), .fy(field_y), .heading(hd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[CORDIC_LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[CORDIC_LAT-1];
        end
    end

    // line the gauss words up with the heading, then merge into the output word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0] <= gx;
            dy_reg[0] <= gy;
            dz_reg[0] <= gz;
            for (int k = 1; k < ALIGN_LAT; k++)
            begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
            end
            gx_reg <= dx_reg[ALIGN_LAT-1];
            gy_reg <= dy_reg[ALIGN_LAT-1];
            gz_reg <= dz_reg[ALIGN_LAT-1];
            hd_reg <= hd;
        end
    end

    assign out_valid   = out_valid_reg;
    assign gauss_x_out = gx_reg;
    assign gauss_y_out = gy_reg;
    assign gauss_z_out = gz_reg;
    assign heading_deg = hd_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    a_gain_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (gain_reg == $past(cfg_wdata)))
        else $error("gain register missed a write");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[CORDIC_LAT-1]))
        else $error("output valid without a word in the pipeline");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hd_reg < DEG360_Q8[HEAD_W-1:0]))
        else $error("heading out of range");
`endif

endmodule
`default_nettype wire

/* tb/magnetometer_field_and_heading_test.sv */
// Testbench for magnetometer_field_and_heading: directed table, then random samples,
// each result checked against a behavioral field and heading calculator.
// Depends on mfh_pkg and the magnetometer_field_and_heading RTL.
`timescale 1ns / 1ps
module magnetometer_field_and_heading_test;
    import mfh_pkg::*;

    typedef struct {
        logic signed [GAUSS_W-1:0] gx;
        logic signed [GAUSS_W-1:0] gy;
        logic signed [GAUSS_W-1:0] gz;
        logic [HEAD_W-1:0]         hdg;
    } reading_t;

    typedef struct {
        logic signed [RAW_W-1:0] x;
        logic signed [RAW_W-1:0] y;
        logic signed [RAW_W-1:0] z;
        bit                      has_hdg;
        logic [HEAD_W-1:0]       hdg;
    } sample_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [GAIN_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic signed [RAW_W-1:0] field_x, field_y, field_z;
    logic out_valid;
    logic out_stall;
    logic signed [GAUSS_W-1:0] gauss_x_out, gauss_y_out, gauss_z_out;
    logic [HEAD_W-1:0] heading_deg;

    int unsigned gain_sel;
    reading_t pending_readings[$];
    int errors;
    bit quiet;   // no idling on either side while set
    bit driving_done;

    localparam int unsigned DIVS [N_GAIN] = '{1370, 1090, 820, 660, 440, 390, 330, 230};
    localparam longint ATANS [CORDIC_ITERS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    magnetometer_field_and_heading dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .field_x(field_x), .field_y(field_y), .field_z(field_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .gauss_x_out(gauss_x_out), .gauss_y_out(gauss_y_out),
        .gauss_z_out(gauss_z_out), .heading_deg(heading_deg)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [GAUSS_W-1:0] to_gauss(longint raw);
        longint q;
        q = ((raw < 0 ? -raw : raw) * 65536) / DIVS[gain_sel];
        return GAUSS_W'(raw < 0 ? -q : q);
    endfunction

    function automatic reading_t convert_sample(longint rx, longint ry, longint rz);
        reading_t r;
        longint ax, ay, cx, cy, cz, xs, ys, ang, h;
        r.gx = to_gauss(rx);
        r.gy = to_gauss(ry);
        r.gz = to_gauss(rz);
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        if (ay == 0)
            ang = 0;
        else if (ax == 0)
            ang = 90 * 256;
        else
        begin
            cx = ax * 16384;
            cy = ay * 16384;
            cz = 0;
            for (int i = 0; i < CORDIC_ITERS; i++)
            begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (cy > 0)
                begin
                    cx += ys; cy -= xs; cz += ATANS[i];
                end
                else
                begin
                    cx -= ys; cy += xs; cz -= ATANS[i];
                end
            end
            if (cz < 0) cz = 0;
            if (cz > 5898240) cz = 5898240;
            ang = (cz + 128) >>> 8;
        end
        if (rx >= 0 && ry >= 0) h = ang;
        else if (rx < 0 && ry >= 0) h = 46080 - ang;
        else if (rx < 0) h = 46080 + ang;
        else h = 92160 - ang;
        if (h >= 92160) h -= 92160;
        if (h < 0) h = 0;
        r.hdg = HEAD_W'(h);
        return r;
    endfunction

    // output side: random stall, check each accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("unexpected result word");
                    errors++;
                end
                else
                begin
                    reading_t e;
                    e = pending_readings.pop_front();
                    if (gauss_x_out !== e.gx)
                    begin
                        $error("gauss_x_out exp %0d got %0d", e.gx, gauss_x_out); errors++;
                    end
                    if (gauss_y_out !== e.gy)
                    begin
                        $error("gauss_y_out exp %0d got %0d", e.gy, gauss_y_out); errors++;
                    end
                    if (gauss_z_out !== e.gz)
                    begin
                        $error("gauss_z_out exp %0d got %0d", e.gz, gauss_z_out); errors++;
                    end
                    if (heading_deg !== e.hdg)
                    begin
                        $error("heading_deg exp %0d got %0d", e.hdg, heading_deg); errors++;
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 27);
        end
    end

    task automatic send_sample(logic signed [RAW_W-1:0] x, logic signed [RAW_W-1:0] y,
                               logic signed [RAW_W-1:0] z, bit has_hdg,
                               logic [HEAD_W-1:0] hdg);
        reading_t e;
        while (!quiet && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        field_x <= x;
        field_y <= y;
        field_z <= z;
        e = convert_sample(x, y, z);
        if (has_hdg && e.hdg !== hdg)
        begin
            $error("heading_deg table exp %0d calc %0d", hdg, e.hdg);
            errors++;
        end
        pending_readings.push_back(e);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_and_set_gain(int unsigned g);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= GAIN_W'(g);
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_sel = g;
    endtask

    function automatic logic signed [RAW_W-1:0] rand_raw();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return RAW_W'($urandom_range(20)) - 16'sd10;
            default: return RAW_W'($urandom());
        endcase
    endfunction

    sample_row_t samples[] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 17'd0},
        '{16'sd100,    16'sd0,      16'sd5,      1'b1, 17'd0},
        '{16'sd0,      16'sd100,    -16'sd5,     1'b1, 17'd23040},
        '{-16'sd100,   16'sd0,      16'sd0,      1'b1, 17'd46080},
        '{16'sd0,      -16'sd100,   16'sd0,      1'b1, 17'd69120},
        '{16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   1'b0, 17'd0},
        '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, 17'd0},
        '{16'sh8000,   16'sh7FFF,   -16'sd1,     1'b0, 17'd0},
        '{16'sh7FFF,   16'sh8000,   16'sd1,      1'b0, 17'd0},
        '{16'sd1,      -16'sd1,     16'sd0,      1'b0, 17'd0},
        '{-16'sd1,     -16'sd1,     16'sd0,      1'b0, 17'd0},
        '{-16'sd1,     16'sd1,      16'sd0,      1'b0, 17'd0},
        '{16'sd30000,  -16'sd1,     16'sd0,      1'b0, 17'd0},
        '{16'sd1,      16'sd30000,  16'sd0,      1'b0, 17'd0},
        '{-16'sd300,   16'sd517,    16'sd999,    1'b0, 17'd0}
    };

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        field_x = '0;
        field_y = '0;
        field_z = '0;
        out_stall = 1'b0;
        gain_sel = 1;
        errors = 0;
        quiet = 1'b0;
        driving_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gain first, then both extremes of the divisor table
        foreach (samples[i])
            send_sample(samples[i].x, samples[i].y, samples[i].z,
                        samples[i].has_hdg, samples[i].hdg);
        drain_and_set_gain(0);
        foreach (samples[i])
            send_sample(samples[i].x, samples[i].y, samples[i].z, 1'b0, '0);
        drain_and_set_gain(7);
        foreach (samples[i])
            send_sample(samples[i].x, samples[i].y, samples[i].z, 1'b0, '0);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_and_set_gain(ph == 0 ? 7 : $urandom_range(7));
            quiet = (ph == 3);
            for (int n = 0; n < 125; n++)
                send_sample(rand_raw(), rand_raw(), rand_raw(), 1'b0, '0);
            quiet = 1'b0;
        end
        in_valid <= 1'b0;

        fork
            begin
                while (pending_readings.size() != 0) @(posedge clk);
                repeat (30) @(posedge clk);
            end
            begin
                repeat (20000) @(posedge clk);
                $error("timed out waiting for results");
                errors++;
            end
        join_any
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
